### rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and the character map for the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3d;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW = 1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_text;
	} out_beat_t;

	// One three-byte group; missing bytes are zero, nbytes is 1 to 3
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  nbytes;
		logic        fin;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 8'h2b;
		end else begin
			c = 8'h2f;
		end
		return c;
	endfunction

endpackage

### rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Takes one message byte per beat and gives four characters per group of
// three bytes, one character beat per cycle while a group is queued and
// char_stall is low; a final byte flushes a partial group with padding and
// the last character carries end_of_text. A byte is taken every cycle while
// the two-entry group queue has room; sustained throughput is set by the
// character output, four characters for every three bytes.
module base64_stream_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  b64e_pkg::in_beat_t  byte_data,
	output logic                char_valid,
	input  logic                char_stall,
	output b64e_pkg::out_beat_t char_data
);

	b64e_pkg::q_status_t q_status;
	b64e_pkg::group_t    push_group;
	b64e_pkg::group_t    head_group;
	logic                push;
	logic                pop;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_status   (q_status),
		.push       (push),
		.push_group (push_group)
	);

	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head_group (head_group),
		.q_status   (q_status)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_group (head_group),
		.q_status   (q_status),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

endmodule

### rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Gathers message bytes into groups of up to three and pushes each group.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  b64e_pkg::in_beat_t  byte_data,
	input  b64e_pkg::q_status_t q_status,
	output logic                push,
	output b64e_pkg::group_t    push_group
);

	logic [1:0]  held_count_q;
	logic [15:0] held_bytes_q;
	logic        accept;
	logic        emit;

	assign byte_stall = q_status.full;
	assign accept     = byte_valid & ~q_status.full;
	assign emit       = held_count_q[1] | byte_data.is_final;
	assign push       = accept & emit;

	always_comb begin
		push_group.fin = byte_data.is_final;
		if (held_count_q[1]) begin
			push_group.bytes  = {held_bytes_q, byte_data.data_byte};
			push_group.nbytes = 2'd3;
		end else if (held_count_q[0]) begin
			push_group.bytes  = {held_bytes_q[15:8], byte_data.data_byte, 8'h00};
			push_group.nbytes = 2'd2;
		end else begin
			push_group.bytes  = {byte_data.data_byte, 16'h0000};
			push_group.nbytes = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			held_bytes_q <= 16'h0000;
		end else if (accept) begin
			if (emit) begin
				held_count_q <= 2'd0;
				held_bytes_q <= 16'h0000;
			end else if (held_count_q[0]) begin
				held_count_q <= 2'd2;
				held_bytes_q <= {held_bytes_q[15:8], byte_data.data_byte};
			end else begin
				held_count_q <= 2'd1;
				held_bytes_q <= {byte_data.data_byte, 8'h00};
			end
		end
	end

endmodule

### rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry group queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64e_pkg::group_t    push_group,
	input  logic                pop,
	output b64e_pkg::group_t    head_group,
	output b64e_pkg::q_status_t q_status
);

	localparam int unsigned CW = b64e_pkg::QUEUE_AW + 1;

	b64e_pkg::group_t               mem_q [b64e_pkg::QUEUE_DEPTH];
	logic [b64e_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [b64e_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [CW-1:0]                  count_q;
	logic                           do_push;
	logic                           do_pop;

	assign q_status.full  = (count_q == CW'(b64e_pkg::QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign do_push        = push & ~q_status.full;
	assign do_pop         = pop & ~q_status.empty;
	assign head_group     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push & ~do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop & ~do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Turns each queued group into four characters, one beat per cycle while char_stall is low.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64e_pkg::group_t    head_group,
	input  b64e_pkg::q_status_t q_status,
	output logic                pop,
	output logic                char_valid,
	input  logic                char_stall,
	output b64e_pkg::out_beat_t char_data
);

	logic [1:0]          idx_q;
	logic                out_valid_q;
	b64e_pkg::out_beat_t out_q;
	logic                load;
	logic                take;
	logic [5:0]          sextet;
	logic                pad;
	b64e_pkg::out_beat_t next_beat;

	assign load       = ~out_valid_q | ~char_stall;
	assign take       = load & ~q_status.empty;
	assign pop        = take & (idx_q == 2'd3);
	assign char_valid = out_valid_q;
	assign char_data  = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    sextet = head_group.bytes[23:18];
			2'd1:    sextet = head_group.bytes[17:12];
			2'd2:    sextet = head_group.bytes[11:6];
			default: sextet = head_group.bytes[5:0];
		endcase
		pad = (idx_q > head_group.nbytes);
		next_beat.out_char    = pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
		next_beat.end_of_text = head_group.fin & (idx_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= ~q_status.empty;
			if (take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= next_beat;
		end
	end

endmodule

### dv/base64_char_checker.sv
// ----------------------------------------------------------------------------
// base64_char_checker
// Watches the byte and character channels of the Base64 stream encoder. It
// keeps its own copy of the pending-byte state, works out the characters due
// for every accepted byte beat and compares each character beat in order.
// ----------------------------------------------------------------------------
module base64_char_checker
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  in_beat_t    byte_data,
	input  logic        char_valid,
	input  logic        char_stall,
	input  out_beat_t   char_data,
	output int unsigned fail_count,
	output int unsigned chars_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic [1:0]  held_cnt = 2'd0;
	logic [15:0] held_bytes = 16'h0000;
	out_beat_t   char_expected_q[$];
	out_beat_t   want;

	initial begin
		fail_count = 0;
		chars_pending = 0;
	end

	function automatic logic [7:0] b64_symbol(input logic [5:0] v);
		return B64_ALPHABET[(63 - v) * 8 +: 8];
	endfunction

	function automatic void queue_char(input logic [7:0] c, input logic eot);
		char_expected_q.push_back('{out_char: c, end_of_text: eot});
	endfunction

	function automatic void encode_byte(input in_beat_t beat);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
		cnt = (held_cnt > 2'd2) ? 2'd2 : held_cnt;
		b0 = held_bytes[15:8];
		b1 = held_bytes[7:0];
		b2 = beat.data_byte;
		if (cnt == 2'd2) begin
			queue_char(b64_symbol(b0[7:2]), 1'b0);
			queue_char(b64_symbol({b0[1:0], b1[7:4]}), 1'b0);
			queue_char(b64_symbol({b1[3:0], b2[7:6]}), 1'b0);
			queue_char(b64_symbol(b2[5:0]), beat.is_final);
			held_cnt = 2'd0;
			held_bytes = 16'h0000;
		end else if (beat.is_final) begin
			if (cnt == 2'd0) begin
				queue_char(b64_symbol(b2[7:2]), 1'b0);
				queue_char(b64_symbol({b2[1:0], 4'b0000}), 1'b0);
				queue_char(PAD_CHAR, 1'b0);
			end else begin
				queue_char(b64_symbol(b0[7:2]), 1'b0);
				queue_char(b64_symbol({b0[1:0], b2[7:4]}), 1'b0);
				queue_char(b64_symbol({b2[3:0], 2'b00}), 1'b0);
			end
			queue_char(PAD_CHAR, 1'b1);
			held_cnt = 2'd0;
			held_bytes = 16'h0000;
		end else begin
			if (cnt == 2'd0) begin
				held_bytes = {b2, 8'h00};
			end else begin
				held_bytes[7:0] = b2;
			end
			held_cnt = cnt + 2'd1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt = 2'd0;
			held_bytes = 16'h0000;
			char_expected_q.delete();
		end else begin
			if (char_valid && !char_stall) begin
				if (char_expected_q.size() == 0) begin
					$error("unexpected char beat: out_char %h end_of_text %b",
						char_data.out_char, char_data.end_of_text);
					fail_count++;
				end else begin
					want = char_expected_q.pop_front();
					if (char_data.out_char !== want.out_char) begin
						$error("out_char: expected %h, actual %h",
							want.out_char, char_data.out_char);
						fail_count++;
					end
					if (char_data.end_of_text !== want.end_of_text) begin
						$error("end_of_text: expected %b, actual %b",
							want.end_of_text, char_data.end_of_text);
						fail_count++;
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				encode_byte(byte_data);
			end
		end
		chars_pending = char_expected_q.size();
	end

endmodule

### dv/base64_stream_encoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Drives byte beats into the Base64 stream encoder: a handful of directed
// messages covering padding, full groups and the extreme symbols, then
// random messages under three idling regimes. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;
	import b64e_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 96;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	in_beat_t    byte_data = '0;
	logic        char_valid;
	logic        char_stall = 1'b0;
	out_beat_t   char_data;
	int unsigned fail_count;
	int unsigned chars_pending;
	int unsigned src_idle_pct = 32;
	int unsigned snk_idle_pct = 69;
	int unsigned cycle_count = 0;

	always #1 clk = ~clk;

	base64_stream_encoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

	base64_char_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_data     (byte_data),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_data     (char_data),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	always @(negedge clk) begin
		char_stall <= ($urandom_range(0, 99) < snk_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{data_byte: b, is_final: fin};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one byte, two pad
		send_byte(8'h00, 1'b1);
		// two bytes, one pad
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		// final byte completes a group: "////" then "++++"
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'hfb, 1'b0);
		send_byte(8'hef, 1'b0);
		send_byte(8'hbe, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h23, 1'b0);
		send_byte(8'h45, 1'b0);
		send_byte(8'h67, 1'b0);
		send_byte(8'h89, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hfe, 1'b0);
		send_byte(8'h01, 1'b1);

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				src_idle_pct = 69;
				snk_idle_pct = 32;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			send_byte(8'($urandom_range(0, 255)),
				(n == RANDOM_ITEMS - 1) || ($urandom_range(0, 3) == 0));
		end
		byte_valid <= 1'b0;

		while (chars_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && chars_pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### base64_stream_encoder.f
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
dv/base64_char_checker.sv
dv/base64_stream_encoder_tb.sv
